[src/slpc_pkg.sv]
// Shared types, constants and type-byte checks for the SIM file list path checker.
package slpc_pkg;

  // File id type bytes.
  localparam logic [7:0] TYPE_MF     = 8'h3F;
  localparam logic [7:0] TYPE_EF_MF  = 8'h2F;
  localparam logic [7:0] TYPE_DF1    = 8'h7F;
  localparam logic [7:0] TYPE_EF_DF1 = 8'h6F;
  localparam logic [7:0] TYPE_DF2    = 8'h5F;
  localparam logic [7:0] TYPE_EF_DF2 = 8'h4F;

  localparam int MAX_PATH_BYTES = 8;
  localparam int MAX_LIST_BYTES = 255;
  localparam int MIN_LIST_BYTES = 5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic        file_ready;
    logic [63:0] path_bytes;
    logic [3:0]  path_length;
    logic        list_done;
    logic        list_ok;
  } result_t;

  function automatic logic is_elementary(input logic [7:0] t);
    return (t == TYPE_EF_MF) || (t == TYPE_EF_DF1) || (t == TYPE_EF_DF2);
  endfunction

  function automatic logic parent_ok(input logic [7:0] t, input logic [7:0] prev);
    logic ok;
    case (t)
      TYPE_MF:     ok = is_elementary(prev);
      TYPE_EF_MF:  ok = (prev == TYPE_MF);
      TYPE_DF1:    ok = (prev == TYPE_MF);
      TYPE_EF_DF1: ok = (prev == TYPE_DF1);
      TYPE_DF2:    ok = (prev == TYPE_DF1);
      TYPE_EF_DF2: ok = (prev == TYPE_DF2);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

[src/sim_file_list_path_checker.sv]
// Top level of the SIM file list path checker: input stage, parser and result register.
// Bytes of a File List object value enter on data_byte with is_last on the final one,
// one transaction per byte over in_valid/in_ready. A transaction on the output channel
// (out_valid/out_ready) carries either a finished elementary-file path (file_ready,
// path_bytes, path_length), the end-of-list verdict (list_done, list_ok), or both.
// Bytes that complete no file and are not last produce no output transaction.
// When list_ok is 0 with list_done, all files given for that list are to be dropped.
// A result passes through the input register, then the result register. The type
// check and path update between the two registers are combinational, so bytes enter
// at one byte per cycle unless a result-producing byte is blocked at a stalled output.
// If the receiver stalls, one result waits in the result register and one more byte
// waits in the input register; bytes that yield no result keep flowing past a stalled
// result. in_ready falls only when a result-producing byte is blocked.
// A synchronous rst empties both registers and returns the path state to its start:
// no path, no error, expected first type 0x3F.
module sim_file_list_path_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        file_ready,
  output logic [63:0] path_bytes,
  output logic [3:0]  path_length,
  output logic        list_done,
  output logic        list_ok
);

  logic                item_valid;
  slpc_pkg::item_t     item;
  logic                fire;
  logic                produces;
  slpc_pkg::result_t   result;
  slpc_pkg::result_t   result_q;
  logic                out_free;
  logic                out_valid_next;

  assign out_free = !out_valid || out_ready;

  slpc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  slpc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .fire       (fire),
    .produces   (produces),
    .result     (result)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (fire && produces) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produces) begin
      result_q <= result;
    end
  end

  assign file_ready  = result_q.file_ready;
  assign path_bytes  = result_q.path_bytes;
  assign path_length = result_q.path_length;
  assign list_done   = result_q.list_done;
  assign list_ok     = result_q.list_ok;

  // Every output transaction reports a file, the end of a list, or both.
  a_out_has_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (file_ready || list_done))
    else $error("output transaction with neither file nor list end");

  // A verdict is only given on the last byte.
  a_ok_only_when_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !list_done |-> !list_ok)
    else $error("list_ok without list_done");

  // Every emitted path starts at the master file.
  a_path_starts_mf: assert property (@(posedge clk) disable iff (rst)
    out_valid && file_ready |-> (path_bytes[63:56] == slpc_pkg::TYPE_MF))
    else $error("emitted path does not start with the master file");

  // Emitted paths hold whole file ids of at least two levels.
  a_path_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && file_ready |-> (path_length == 4'd4 || path_length == 4'd6 ||
                                 path_length == 4'd8))
    else $error("emitted path has an odd or short length");

  // A result-producing byte never retires while a stalled result still occupies the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(fire && produces))
    else $error("result register overwritten while stalled");

endmodule

[src/slpc_in_stage.sv]
// Input register stage that holds one accepted byte until the parser consumes it.
module slpc_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               is_last,
  input  logic               fire,
  output logic               item_valid,
  output slpc_pkg::item_t    item
);

  logic item_valid_next;

  assign in_ready = !item_valid || fire;

  always_comb begin
    item_valid_next = item_valid;
    if (in_valid && in_ready) begin
      item_valid_next = 1'b1;
    end else if (fire) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte <= data_byte;
      item.is_last   <= is_last;
    end
  end

endmodule

[src/slpc_parse.sv]
// Path state and combinational type check for one file list byte.
module slpc_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  slpc_pkg::item_t    item,
  input  logic               out_free,
  output logic               fire,
  output logic               produces,
  output slpc_pkg::result_t  result
);

  logic [7:0]  pos, pos_next;
  logic [7:0]  prev, prev_next;
  logic [7:0]  held, held_next;
  logic [63:0] path, path_next;
  logic [3:0]  len, len_next;
  logic        err, err_next;

  logic        append_ok;
  logic [63:0] appended;
  logic        file_ready;
  logic [7:0]  b;

  assign b         = item.data_byte;
  assign append_ok = (len < 4'(slpc_pkg::MAX_PATH_BYTES));
  assign appended  = path | ({b, 56'h0} >> {len[2:0], 3'b000});

  always_comb begin
    pos_next   = pos;
    prev_next  = prev;
    held_next  = held;
    path_next  = path;
    len_next   = len;
    err_next   = err;
    file_ready = 1'b0;

    if (pos >= 8'(slpc_pkg::MAX_LIST_BYTES)) begin
      err_next = 1'b1;
    end else if (!err && (pos != 8'd0)) begin
      if (pos[0]) begin
        // Odd positions carry the type byte of a file id.
        if (pos == 8'd1) begin
          if (b != slpc_pkg::TYPE_MF) begin
            err_next = 1'b1;
          end else begin
            path_next = {b, 56'h0};
            len_next  = 4'd1;
          end
          held_next = b;
        end else if (!slpc_pkg::parent_ok(b, prev)) begin
          err_next = 1'b1;
        end else begin
          if (b == slpc_pkg::TYPE_MF) begin
            path_next = {b, 56'h0};
            len_next  = 4'd1;
          end else if (append_ok) begin
            path_next = appended;
            len_next  = len + 4'd1;
          end else begin
            err_next = 1'b1;
          end
          held_next = b;
          prev_next = b;
        end
      end else begin
        if (!append_ok) begin
          err_next = 1'b1;
        end else begin
          path_next = appended;
          len_next  = len + 4'd1;
          if ((pos >= 8'(slpc_pkg::MIN_LIST_BYTES - 1)) && slpc_pkg::is_elementary(held)) begin
            file_ready = 1'b1;
          end
        end
      end
    end

    if (pos < 8'(slpc_pkg::MAX_LIST_BYTES)) begin
      pos_next = pos + 8'd1;
    end

    result.file_ready  = file_ready;
    result.path_bytes  = file_ready ? path_next : 64'h0;
    result.path_length = file_ready ? len_next : 4'h0;
    result.list_done   = item.is_last;
    result.list_ok     = item.is_last && !err_next &&
                         (pos >= 8'(slpc_pkg::MIN_LIST_BYTES - 1)) && !pos[0] &&
                         slpc_pkg::is_elementary(prev_next);

    // The last byte returns the parser to its reset state for the next list.
    if (item.is_last) begin
      pos_next  = 8'd0;
      prev_next = slpc_pkg::TYPE_MF;
      held_next = 8'd0;
      path_next = 64'h0;
      len_next  = 4'd0;
      err_next  = 1'b0;
    end
  end

  assign produces = file_ready || item.is_last;
  // A byte that yields no result can retire even while the output is stalled.
  assign fire     = item_valid && (out_free || !produces);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= 8'd0;
      prev <= slpc_pkg::TYPE_MF;
      held <= 8'd0;
      path <= 64'h0;
      len  <= 4'd0;
      err  <= 1'b0;
    end else if (fire) begin
      pos  <= pos_next;
      prev <= prev_next;
      held <= held_next;
      path <= path_next;
      len  <= len_next;
      err  <= err_next;
    end
  end

endmodule
